FILE: rtl/abo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_pkg: shared types and helpers for the alpha over blend pipeline
// Register indexes, blend modes, stage payloads and byte arithmetic helpers.
// ----------------------------------------------------------------------------
package abo_pkg;

  localparam int unsigned NUM_CH     = 3;  // red, green, blue
  localparam int unsigned DIV_STAGES = 8;  // one quotient bit per stage

  typedef enum logic {
    REG_BLEND_MODE = 1'b0,
    REG_FILL_COLOR = 1'b1
  } abo_reg_t;

  typedef enum logic {
    MODE_FILL   = 1'b0,
    MODE_PREMUL = 1'b1
  } abo_mode_t;

  // Products registered after the first stage
  typedef struct packed {
    abo_mode_t                  mode;
    logic [7:0]                 a;
    logic [7:0]                 inv;
    logic [31:0]                src;
    logic [NUM_CH-1:0][15:0]    ca;
    logic [NUM_CH-1:0][15:0]    dcda;
    logic [15:0]                dainv;
    logic [NUM_CH-1:0][15:0]    dcinv;
  } abo_prod_t;

  // Divider payload; pre carries the finished premultiplied pixel or the
  // fill-mode alpha byte
  typedef struct packed {
    abo_mode_t                  mode;
    logic                       dz;
    logic [22:0]                dsh;
    logic [NUM_CH-1:0][25:0]    rem;
    logic [NUM_CH-1:0][7:0]     q;
    logic [31:0]                pre;
  } abo_div_t;

  // floor(x / 255), exact for x <= 65025
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

  function automatic logic [7:0] sat_add(input logic [7:0] x, input logic [7:0] y);
    logic [8:0] s;
    s = {1'b0, x} + {1'b0, y};
    return s[8] ? 8'hff : s[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/abo_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_in_if: input pixel channel
// Valid/ready channel carrying a destination and a source pixel.
// ----------------------------------------------------------------------------
interface abo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] dest_pixel;
  logic [31:0] src_pixel;

  modport source(output valid, output dest_pixel, output src_pixel, input ready);
  modport sink(input valid, input dest_pixel, input src_pixel, output ready);
endinterface
`default_nettype wire

FILE: rtl/abo_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_out_if: output pixel channel
// Valid/ready channel carrying the blended pixel.
// ----------------------------------------------------------------------------
interface abo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_pixel;

  modport source(output valid, output out_pixel, input ready);
  modport sink(input valid, input out_pixel, output ready);
endinterface
`default_nettype wire

FILE: rtl/abo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_front: product and sum stages
// Stage 1 forms the 8x8 products, stage 2 the fill-mode numerators,
// denominator and alpha byte and the complete premultiplied result.
// ----------------------------------------------------------------------------
module abo_front (
  input  logic               clk,
  input  logic               rst,
  input  abo_pkg::abo_mode_t mode,
  input  logic [31:0]        fill_color,
  abo_in_if.sink             pix_in,
  output logic               out_valid,
  input  logic               out_ready,
  output abo_pkg::abo_div_t  out_data
);
  import abo_pkg::*;

  logic      s1_valid;
  logic      s1_ready;
  abo_prod_t s1;
  abo_prod_t s1_next;
  logic      s2_valid;
  logic      s2_ready;
  abo_div_t  s2;
  abo_div_t  s2_next;

  assign s2_ready     = ~s2_valid | out_ready;
  assign s1_ready     = ~s1_valid | s2_ready;
  assign pix_in.ready = s1_ready;
  assign out_valid    = s2_valid;
  assign out_data     = s2;

  always_comb begin
    logic [31:0] srcp;
    logic [7:0]  da;
    logic [7:0]  dc;
    srcp = (mode == MODE_FILL) ? fill_color : pix_in.src_pixel;
    da   = pix_in.dest_pixel[31:24];
    s1_next.mode  = mode;
    s1_next.a     = srcp[31:24];
    s1_next.inv   = 8'd255 - srcp[31:24];
    s1_next.src   = srcp;
    s1_next.dainv = {8'b0, da} * {8'b0, s1_next.inv};
    for (int c = 0; c < NUM_CH; c++) begin
      dc = pix_in.dest_pixel[8*c +: 8];
      s1_next.ca[c]    = {8'b0, srcp[8*c +: 8]} * {8'b0, srcp[31:24]};
      s1_next.dcda[c]  = {8'b0, dc} * {8'b0, da};
      s1_next.dcinv[c] = {8'b0, dc} * {8'b0, s1_next.inv};
    end
  end

  always_comb begin
    logic [23:0] prod;
    logic [15:0] d;
    d = {s1.a, 8'b0} - {8'b0, s1.a} + s1.dainv;
    s2_next.mode = s1.mode;
    s2_next.dz   = (d == 16'd0);
    s2_next.dsh  = {d, 7'b0};
    for (int c = 0; c < NUM_CH; c++) begin
      prod = {8'b0, s1.dcda[c]} * {16'b0, s1.inv};
      s2_next.rem[c] = {2'b0, s1.ca[c], 8'b0} - {10'b0, s1.ca[c]} + {2'b0, prod};
      s2_next.q[c]   = 8'd0;
    end
    if (s1.mode == MODE_FILL) begin
      s2_next.pre = {div255(d), 24'd0};
    end else begin
      s2_next.pre[31:24] = sat_add(s1.a, div255(s1.dainv));
      for (int c = 0; c < NUM_CH; c++) begin
        s2_next.pre[8*c +: 8] = sat_add(s1.src[8*c +: 8], div255(s1.dcinv[c]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= pix_in.valid;
      if (s2_ready) s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_in.valid && s1_ready) s1 <= s1_next;
    if (s1_valid && s2_ready)     s2 <= s2_next;
  end

  // fill-mode numerators never exceed 255 times the denominator
  a_num_bound: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2.mode == MODE_FILL |->
      s2.rem[0] <= {3'b0, s2.dsh} + {3'b0, s2.dsh} - {10'b0, s2.dsh[22:7]} &&
      s2.rem[1] <= {3'b0, s2.dsh} + {3'b0, s2.dsh} - {10'b0, s2.dsh[22:7]} &&
      s2.rem[2] <= {3'b0, s2.dsh} + {3'b0, s2.dsh} - {10'b0, s2.dsh[22:7]})
    else $error("fill numerator above 255 * denominator");

endmodule
`default_nettype wire

FILE: rtl/abo_div_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// abo_div_stage: one restoring division step
// Resolves one quotient bit for each colour channel and halves the shifted
// divisor for the next stage.
// ----------------------------------------------------------------------------
module abo_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  abo_pkg::abo_div_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output abo_pkg::abo_div_t out_data
);
  import abo_pkg::*;

  logic     valid;
  abo_div_t data;
  abo_div_t data_next;

  assign in_ready  = ~valid | out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    logic [25:0] dv;
    logic        take;
    data_next     = in_data;
    data_next.dsh = in_data.dsh >> 1;
    dv = {3'b0, in_data.dsh};
    for (int c = 0; c < NUM_CH; c++) begin
      take = (in_data.rem[c] >= dv);
      data_next.rem[c] = take ? in_data.rem[c] - dv : in_data.rem[c];
      data_next.q[c]   = {in_data.q[c][6:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) data <= data_next;
  end

  // remainder stays below the divisor that was just compared
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid && data.mode == MODE_FILL |->
      data.rem[0] < {2'b0, data.dsh, 1'b1} &&
      data.rem[1] < {2'b0, data.dsh, 1'b1} &&
      data.rem[2] < {2'b0, data.dsh, 1'b1})
    else $error("division remainder out of range");

endmodule
`default_nettype wire

FILE: rtl/alpha_over_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_over_blend: Porter-Duff over compositing of ARGB8888 pixels
// Fill-colour mode with exact division by output alpha, or premultiplied
// per-pixel source mode; APB-style register port.
// ----------------------------------------------------------------------------
// Takes one pixel pair per cycle while the output side does not stall, and
// returns each blended pixel after the product and sum stages and then eight
// one-bit restoring division steps that give the fill-mode colour quotients.
// Every stage carries its own valid bit and only stalls when it is full and
// the stage after it is blocked, so a waiting result does not stop new
// pixels from entering empty slots.
// Registers: blend_mode at 0x0, fill_color at 0x4. Change them only while
// no pixel is in flight.
module alpha_over_blend (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  abo_in_if.sink      pix_in,
  abo_out_if.source   pix_out
);
  import abo_pkg::*;

  abo_mode_t   blend_mode;
  logic [31:0] fill_color;
  abo_reg_t    reg_sel;
  logic        reg_write;

  logic     stg_valid [DIV_STAGES+1];
  logic     stg_ready [DIV_STAGES+1];
  abo_div_t stg_data  [DIV_STAGES+1];
  abo_div_t last;

  assign pready    = 1'b1;
  assign reg_sel   = abo_reg_t'(paddr[2]);
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_FILL;
      fill_color <= 32'd0;
    end else if (reg_write) begin
      unique case (reg_sel)
        REG_BLEND_MODE: blend_mode <= abo_mode_t'(pwdata[0]);
        REG_FILL_COLOR: fill_color <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BLEND_MODE: prdata = {31'd0, blend_mode};
      REG_FILL_COLOR: prdata = fill_color;
      default:        prdata = 32'd0;
    endcase
  end

  abo_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (blend_mode),
    .fill_color (fill_color),
    .pix_in     (pix_in),
    .out_valid  (stg_valid[0]),
    .out_ready  (stg_ready[0]),
    .out_data   (stg_data[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    abo_div_stage u_div (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_valid[i]),
      .in_ready  (stg_ready[i]),
      .in_data   (stg_data[i]),
      .out_valid (stg_valid[i+1]),
      .out_ready (stg_ready[i+1]),
      .out_data  (stg_data[i+1])
    );
  end

  assign last                 = stg_data[DIV_STAGES];
  assign stg_ready[DIV_STAGES] = pix_out.ready;
  assign pix_out.valid        = stg_valid[DIV_STAGES];

  always_comb begin
    if (last.mode == MODE_PREMUL) begin
      pix_out.out_pixel = last.pre;
    end else if (last.dz) begin
      pix_out.out_pixel = 32'd0;
    end else begin
      pix_out.out_pixel = {last.pre[31:24], last.q[2], last.q[1], last.q[0]};
    end
  end

  // zero output alpha in fill mode means a fully transparent pixel
  a_zero_alpha: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && last.mode == MODE_FILL && last.pre[31:24] == 8'd0 |->
      pix_out.out_pixel[23:0] == 24'd0)
    else $error("transparent fill result has colour");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    reg_write && reg_sel == REG_BLEND_MODE |=> blend_mode == abo_mode_t'($past(pwdata[0])))
    else $error("blend_mode write lost");

endmodule
`default_nettype wire

FILE: verif/alpha_over_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_over_blend_tb: self-checking bench for the over-operator pixel blender
// Drives pixel pairs in random bursts through the input channel, stalls the
// output channel on its own random pattern, and compares each blended pixel
// against an in-bench integer predictor for fill-colour and premultiplied
// modes. Registers are programmed and read back over the APB port when idle.
// ----------------------------------------------------------------------------
module alpha_over_blend_tb;
  import abo_pkg::*;

  localparam int unsigned PIPE_DEPTH = 10;
  localparam int unsigned SETTLE     = PIPE_DEPTH + 4;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  abo_in_if  pix_in();
  abo_out_if pix_out();

  alpha_over_blend u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  // register shadows used by the predictor
  abo_mode_t   mode_shadow;
  logic [31:0] fill_shadow;

  logic [31:0] blended_q[$];
  int unsigned err_count;

  // sender burst / gap control and receiver stall control
  int unsigned max_gap;
  int unsigned max_stall;
  int unsigned burst_left;

  initial begin
    clk = 1'b0;
  end
  always #4 clk = ~clk;

  function automatic logic [7:0] sat8(input int unsigned v);
    return (v > 255) ? 8'hff : v[7:0];
  endfunction

  // Porter-Duff over for one pixel pair, exact integer math
  function automatic logic [31:0] over_pixel(input abo_mode_t mode, input logic [31:0] fill,
                                             input logic [31:0] src, input logic [31:0] dst);
    int unsigned a, da, inv, d, n, i;
    logic [31:0] res;
    res = '0;
    if (mode == MODE_FILL) begin
      a   = fill[31:24];
      da  = dst[31:24];
      inv = 255 - a;
      d   = a * 255 + da * inv;
      res[31:24] = sat8(d / 255);
      for (i = 0; i < 3; i++) begin
        n = 255 * fill[8*i +: 8] * a + dst[8*i +: 8] * da * inv;
        res[8*i +: 8] = (d == 0) ? 8'h00 : sat8(n / d);
      end
    end else begin
      inv = 255 - src[31:24];
      for (i = 0; i < 4; i++)
        res[8*i +: 8] = sat8(src[8*i +: 8] + (dst[8*i +: 8] * inv) / 255);
    end
    return res;
  endfunction

  // bytes lean toward 0 and 255 so the formula edges are hit often
  function automatic logic [7:0] pick_byte();
    int unsigned sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] pick_pixel();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
  endfunction

  // premultiplied source: color channels not above alpha, except now and then
  function automatic logic [31:0] pick_premul();
    logic [7:0] a;
    if ($urandom_range(0, 4) == 0) return pick_pixel();
    a = pick_byte();
    return {a, 8'($urandom_range(0, a)), 8'($urandom_range(0, a)), 8'($urandom_range(0, a))};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR @%0t: %s: got %08h expected %08h", $realtime, what, got, want);
    err_count++;
  endtask

  // one transaction on the input channel; valid stays high inside a burst
  task automatic push_pixel(input logic [31:0] dst, input logic [31:0] src);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
      if (gap != 0) begin
        pix_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_in.valid      <= 1'b1;
    pix_in.dest_pixel <= dst;
    pix_in.src_pixel  <= src;
    do @(posedge clk); while (!pix_in.ready);
    blended_q.push_back(over_pixel(mode_shadow, fill_shadow, src, dst));
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    burst_left = 0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input abo_reg_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write a register while the pipe is empty, then read it back
  task automatic set_reg(input abo_reg_t idx, input logic [31:0] value);
    logic [31:0] rd;
    logic [31:0] want;
    wait_idle();
    apb_xfer(1'b1, idx, value, rd);
    if (idx == REG_BLEND_MODE) begin
      mode_shadow = abo_mode_t'(value[0]);
      want = {31'b0, value[0]};
    end else begin
      fill_shadow = value;
      want = value;
    end
    @(posedge clk);
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== want) report_mismatch("register readback", rd, want);
  endtask

  // fill mode corners: zero output alpha, opaque and clear fill, ignored source
  task automatic test_fill_corners();
    push_pixel(32'h0000_0000, 32'hffff_ffff);
    push_pixel(32'h00ff_ffff, 32'h1234_5678);
    push_pixel(32'hffff_ffff, 32'h0000_0000);
    set_reg(REG_BLEND_MODE, {31'b0, MODE_FILL});
    set_reg(REG_FILL_COLOR, 32'hffff_ffff);
    push_pixel(32'h0000_0000, 32'h0000_0000);
    push_pixel(32'hffff_ffff, 32'hffff_ffff);
    push_pixel(32'h8012_3456, $urandom);
    set_reg(REG_FILL_COLOR, 32'h00ff_00ff);
    push_pixel(32'h80ff_8001, $urandom);
    push_pixel(32'h0000_0000, $urandom);
    push_pixel(32'hff00_ff00, $urandom);
    set_reg(REG_FILL_COLOR, 32'h80ff_8000);
    push_pixel(32'hff00_00ff, $urandom);
    push_pixel(32'h01ff_ffff, $urandom);
    push_pixel(32'h0000_0000, $urandom);
  endtask

  // premultiplied corners, including sources with a channel above alpha
  task automatic test_premul_corners();
    set_reg(REG_BLEND_MODE, {31'b0, MODE_PREMUL});
    push_pixel(32'h0000_0000, 32'h0000_0000);
    push_pixel(32'hffff_ffff, 32'hffff_ffff);
    push_pixel(32'hffff_ffff, 32'h0000_0000);
    push_pixel(32'hffff_ffff, 32'h10ff_ffff);
    push_pixel(32'hffff_ffff, 32'h8080_8080);
    push_pixel(32'h0000_0000, 32'h00ff_ffff);
    push_pixel($urandom, 32'hff00_0000);
    push_pixel(32'h7f7f_7f7f, 32'h0101_0101);
  endtask

  task automatic test_fill_random();
    int unsigned k, i;
    set_reg(REG_BLEND_MODE, {31'b0, MODE_FILL});
    for (k = 0; k < 6; k++) begin
      case (k)
        0: set_reg(REG_FILL_COLOR, 32'h0000_0000);
        1: set_reg(REG_FILL_COLOR, 32'hffff_ffff);
        2: set_reg(REG_FILL_COLOR, {8'h00, 24'($urandom)});
        default: set_reg(REG_FILL_COLOR, $urandom);
      endcase
      for (i = 0; i < 120; i++) push_pixel(pick_pixel(), $urandom);
    end
  endtask

  task automatic test_premul_random();
    int unsigned i;
    set_reg(REG_BLEND_MODE, {31'b0, MODE_PREMUL});
    set_reg(REG_FILL_COLOR, $urandom);
    for (i = 0; i < 600; i++) push_pixel(pick_pixel(), pick_premul());
  endtask

  // back-to-back transactions with the receiver always ready
  task automatic test_full_rate();
    int unsigned i;
    max_gap   = 0;
    max_stall = 0;
    set_reg(REG_BLEND_MODE, {31'b0, MODE_PREMUL});
    for (i = 0; i < 100; i++) push_pixel(pick_pixel(), pick_premul());
    set_reg(REG_BLEND_MODE, {31'b0, MODE_FILL});
    set_reg(REG_FILL_COLOR, $urandom);
    for (i = 0; i < 100; i++) push_pixel(pick_pixel(), $urandom);
    max_gap   = 6;
    max_stall = 12;
  endtask

  // receiver: ready runs and stalls of random length
  initial begin
    int unsigned run;
    run = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (run == 0) begin
        if (pix_out.ready === 1'b1 && max_stall != 0) begin
          pix_out.ready <= 1'b0;
          run = $urandom_range(1, max_stall);
        end else begin
          pix_out.ready <= 1'b1;
          run = $urandom_range(1, 20);
        end
      end else begin
        run--;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (blended_q.size() == 0)
        report_mismatch("out_pixel with nothing outstanding", pix_out.out_pixel, '0);
      else if (pix_out.out_pixel !== blended_q[0])
        report_mismatch("out_pixel", pix_out.out_pixel, blended_q.pop_front());
      else
        void'(blended_q.pop_front());
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    err_count   = 0;
    mode_shadow = MODE_FILL;
    fill_shadow = '0;
    max_gap     = 6;
    max_stall   = 12;
    burst_left  = 0;
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    pix_in.valid      <= 1'b0;
    pix_in.dest_pixel <= '0;
    pix_in.src_pixel  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_fill_corners();
    test_premul_corners();
    test_fill_random();
    test_premul_random();
    test_full_rate();

    wait_idle();
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/abo_pkg.sv
rtl/abo_in_if.sv
rtl/abo_out_if.sv
rtl/abo_front.sv
rtl/abo_div_stage.sv
rtl/alpha_over_blend.sv
verif/alpha_over_blend_tb.sv
